// File: rtl/sprite_command_list_sequencer_core_assert.svh
// Assertion macros used by the sequencer core top level.
`ifndef SPRITE_COMMAND_LIST_SEQUENCER_CORE_ASSERT_SVH
`define SPRITE_COMMAND_LIST_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SCLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");
// Next-cycle implication, checked outside reset.
`define SCLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");
// Invariant that holds at every edge.
`define SCLS_ASSERT_ALW(lbl, clk, cond) \
    lbl: assert property (@(posedge clk) (cond)) \
        else $error("sequencer assertion failed");
`else
`define SCLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SCLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define SCLS_ASSERT_ALW(lbl, clk, cond)
`endif
`endif

// File: rtl/scls_pkg.sv
// Types, constants and the draw kind table of the command list sequencer.
`timescale 1ns / 1ps
package scls_pkg;

    // Word address width of the command table.
    localparam int ADDR_BITS = 18;

    // Control word layout.
    localparam int CTL_END_BIT  = 15;
    localparam int CTL_SKIP_BIT = 14;

    // Command codes.
    localparam logic [3:0] CODE_USER_CLIP   = 4'h8;
    localparam logic [3:0] CODE_SYSTEM_CLIP = 4'h9;
    localparam logic [3:0] CODE_LOCAL_ORG   = 4'hA;
    localparam logic [3:0] CODE_USER_CLIP2  = 4'hB;
    localparam logic [3:0] CODE_STOP_MIN    = 4'hC;

    // Address step between consecutive commands, in words.
    localparam logic [ADDR_BITS-1:0] CMD_STRIDE = ADDR_BITS'(16);

    // Reported drawing kinds.
    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_NORMAL    = 3'd1;
    localparam logic [2:0] KIND_SCALED    = 3'd2;
    localparam logic [2:0] KIND_DISTORTED = 3'd3;
    localparam logic [2:0] KIND_POLYGON   = 3'd4;
    localparam logic [2:0] KIND_POLYLINE  = 3'd5;
    localparam logic [2:0] KIND_LINE      = 3'd6;

    // Link modes from control word bits 13:12.
    typedef enum logic [1:0] {
        LINK_NEXT   = 2'd0,
        LINK_JUMP   = 2'd1,
        LINK_CALL   = 2'd2,
        LINK_RETURN = 2'd3
    } t_link;

    // A classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic                 is_start;
        logic                 is_end;
        logic                 is_stop;
        logic                 load_uclip;
        logic                 load_sclip;
        logic                 load_origin;
        logic [2:0]           kind;
        t_link                link;
        logic [ADDR_BITS-1:0] target;
        logic [10:0]          coord_a;
        logic [10:0]          coord_b;
        logic [9:0]           coord_c;
        logic [8:0]           coord_d;
    } t_cmd;

    // Queue status seen by the front end and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Drawing kind of the codes below eight.
    function automatic logic [2:0] kind_of_code(input logic [2:0] code);
        logic [2:0] kind;
        case (code)
            3'd0:    kind = KIND_NORMAL;
            3'd1:    kind = KIND_SCALED;
            3'd2:    kind = KIND_DISTORTED;
            3'd3:    kind = KIND_DISTORTED;
            3'd4:    kind = KIND_POLYGON;
            3'd5:    kind = KIND_POLYLINE;
            3'd6:    kind = KIND_LINE;
            3'd7:    kind = KIND_POLYLINE;
            default: kind = KIND_NONE;
        endcase
        return kind;
    endfunction

endpackage

// File: rtl/scls_fifo.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module scls_fifo
    import scls_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  logic       i_pop,
    output t_cmd       o_cmd,
    output t_fifo_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             w_push, w_pop;

    // Status and guarded handshakes.
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/scls_front.sv
// Front end: accepts requests and classifies each command for the back end.
`timescale 1ns / 1ps
module scls_front
    import scls_pkg::*;
(
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_control_word,
    input  logic [15:0] i_link_word,
    input  logic [15:0] i_coord_word_a,
    input  logic [15:0] i_coord_word_b,
    input  logic [15:0] i_coord_word_c,
    input  logic [15:0] i_coord_word_d,
    input  t_fifo_stat  i_stat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       w_skip;
    logic [3:0] w_code;
    logic       w_exec;

    // The queue decides whether a request can be taken.
    assign o_stall = i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    assign w_skip = i_control_word[CTL_SKIP_BIT];
    assign w_code = i_control_word[3:0];
    // A command that is neither skipped nor a stop code is carried out.
    assign w_exec = !w_skip && (w_code < CODE_STOP_MIN);

    // Decode the control word into flags for the back end.
    always_comb begin
        o_cmd.is_start    = !i_mode;
        o_cmd.is_end      = i_control_word[CTL_END_BIT];
        o_cmd.is_stop     = !w_skip && (w_code >= CODE_STOP_MIN);
        o_cmd.load_uclip  = w_exec && ((w_code == CODE_USER_CLIP) ||
                                       (w_code == CODE_USER_CLIP2));
        o_cmd.load_sclip  = w_exec && (w_code == CODE_SYSTEM_CLIP);
        o_cmd.load_origin = w_exec && (w_code == CODE_LOCAL_ORG);
        o_cmd.kind        = (w_exec && !w_code[3]) ? kind_of_code(w_code[2:0]) : KIND_NONE;
        o_cmd.link        = t_link'(i_control_word[13:12]);
        // The link word counts four-word units; the low four address bits are cleared.
        o_cmd.target      = {i_link_word[15:2], 4'b0000};
        o_cmd.coord_a     = i_coord_word_a[10:0];
        o_cmd.coord_b     = i_coord_word_b[10:0];
        o_cmd.coord_c     = i_coord_word_c[9:0];
        o_cmd.coord_d     = i_coord_word_d[8:0];
    end

endmodule

// File: rtl/scls_back.sv
// Back end: carries out queued commands and holds the result register.
`timescale 1ns / 1ps
module scls_back
    import scls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_fifo_stat           i_stat,
    input  t_cmd                 i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_BITS-1:0] o_next_address,
    output logic                 o_drawing_active,
    output logic                 o_end_flag,
    output logic [2:0]           o_draw_kind,
    output logic signed [10:0]   o_origin_x,
    output logic signed [10:0]   o_origin_y,
    output logic [9:0]           o_user_clip_left,
    output logic [8:0]           o_user_clip_top,
    output logic [9:0]           o_user_clip_right,
    output logic [8:0]           o_user_clip_bottom,
    output logic [9:0]           o_system_clip_right,
    output logic [8:0]           o_system_clip_bottom
);

    logic                 r_valid,    n_valid;
    logic [ADDR_BITS-1:0] r_addr,     n_addr;
    logic [ADDR_BITS-1:0] r_ret_addr, n_ret_addr;
    logic                 r_ret_vld,  n_ret_vld;
    logic                 r_active,   n_active;
    logic                 r_end,      n_end;
    logic [2:0]           r_kind,     n_kind;
    logic signed [10:0]   r_org_x,    n_org_x;
    logic signed [10:0]   r_org_y,    n_org_y;
    logic [9:0]           r_ucl_x0,   n_ucl_x0;
    logic [8:0]           r_ucl_y0,   n_ucl_y0;
    logic [9:0]           r_ucl_x1,   n_ucl_x1;
    logic [8:0]           r_ucl_y1,   n_ucl_y1;
    logic [9:0]           r_scl_x,    n_scl_x;
    logic [8:0]           r_scl_y,    n_scl_y;
    logic [ADDR_BITS-1:0] w_addr_inc;

    // A request is taken when the result register is free or being emptied.
    // The state only moves on a pop, so it doubles as the held result.
    assign o_pop      = !i_stat.empty && (!r_valid || !i_stall);
    assign w_addr_inc = r_addr + CMD_STRIDE;

    always_comb begin
        n_valid    = o_pop ? 1'b1 : (r_valid && i_stall);
        n_addr     = r_addr;
        n_ret_addr = r_ret_addr;
        n_ret_vld  = r_ret_vld;
        n_active   = r_active;
        n_end      = r_end;
        n_kind     = r_kind;
        n_org_x    = r_org_x;
        n_org_y    = r_org_y;
        n_ucl_x0   = r_ucl_x0;
        n_ucl_y0   = r_ucl_y0;
        n_ucl_x1   = r_ucl_x1;
        n_ucl_y1   = r_ucl_y1;
        n_scl_x    = r_scl_x;
        n_scl_y    = r_scl_y;
        if (o_pop) begin
            n_kind = KIND_NONE;
            if (i_cmd.is_start) begin
                // Restart the walk at the top of the table.
                n_end      = 1'b0;
                n_addr     = '0;
                n_ret_addr = '0;
                n_ret_vld  = 1'b0;
                n_active   = 1'b1;
            end else if (r_active) begin
                if (i_cmd.is_end) begin
                    n_active = 1'b0;
                    n_end    = 1'b1;
                end else if (i_cmd.is_stop) begin
                    n_active = 1'b0;
                end else begin
                    n_kind = i_cmd.kind;
                    if (i_cmd.load_uclip) begin
                        n_ucl_x0 = i_cmd.coord_a[9:0];
                        n_ucl_y0 = i_cmd.coord_b[8:0];
                        n_ucl_x1 = i_cmd.coord_c;
                        n_ucl_y1 = i_cmd.coord_d;
                    end
                    if (i_cmd.load_sclip) begin
                        n_scl_x = i_cmd.coord_c;
                        n_scl_y = i_cmd.coord_d;
                    end
                    if (i_cmd.load_origin) begin
                        n_org_x = $signed(i_cmd.coord_a);
                        n_org_y = $signed(i_cmd.coord_b);
                    end
                    // Advance, then apply the link mode.
                    case (i_cmd.link)
                        LINK_NEXT: begin
                            n_addr = w_addr_inc;
                        end
                        LINK_JUMP: begin
                            n_addr = i_cmd.target;
                        end
                        LINK_CALL: begin
                            // The single return slot is only filled when empty.
                            if (!r_ret_vld) begin
                                n_ret_addr = w_addr_inc;
                                n_ret_vld  = 1'b1;
                            end
                            n_addr = i_cmd.target;
                        end
                        LINK_RETURN: begin
                            if (r_ret_vld) begin
                                n_addr    = r_ret_addr;
                                n_ret_vld = 1'b0;
                            end else begin
                                n_addr = w_addr_inc;
                            end
                        end
                        default: begin
                            n_addr = w_addr_inc;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_addr     <= '0;
            r_ret_addr <= '0;
            r_ret_vld  <= 1'b0;
            r_active   <= 1'b0;
            r_end      <= 1'b0;
            r_kind     <= KIND_NONE;
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_ucl_x0   <= '0;
            r_ucl_y0   <= '0;
            r_ucl_x1   <= '0;
            r_ucl_y1   <= '0;
            r_scl_x    <= '0;
            r_scl_y    <= '0;
        end else begin
            r_valid    <= n_valid;
            r_addr     <= n_addr;
            r_ret_addr <= n_ret_addr;
            r_ret_vld  <= n_ret_vld;
            r_active   <= n_active;
            r_end      <= n_end;
            r_kind     <= n_kind;
            r_org_x    <= n_org_x;
            r_org_y    <= n_org_y;
            r_ucl_x0   <= n_ucl_x0;
            r_ucl_y0   <= n_ucl_y0;
            r_ucl_x1   <= n_ucl_x1;
            r_ucl_y1   <= n_ucl_y1;
            r_scl_x    <= n_scl_x;
            r_scl_y    <= n_scl_y;
        end
    end

    assign o_valid              = r_valid;
    assign o_next_address       = r_addr;
    assign o_drawing_active     = r_active;
    assign o_end_flag           = r_end;
    assign o_draw_kind          = r_kind;
    assign o_origin_x           = r_org_x;
    assign o_origin_y           = r_org_y;
    assign o_user_clip_left     = r_ucl_x0;
    assign o_user_clip_top      = r_ucl_y0;
    assign o_user_clip_right    = r_ucl_x1;
    assign o_user_clip_bottom   = r_ucl_y1;
    assign o_system_clip_right  = r_scl_x;
    assign o_system_clip_bottom = r_scl_y;

endmodule

// File: rtl/sprite_command_list_sequencer_core.sv
// Top level of the sprite command list sequencer: front end, queue and back end.
//
//  Channel   Direction  Handshake           Payload
//  input     in         i_valid / o_stall   i_mode, i_control_word, i_link_word, i_coord_word_*
//  output    out        o_valid / i_stall   o_next_address ... o_system_clip_bottom
//
// One request is taken every cycle while the queue has room; each gives one result.
// A taken request is written into the queue, and is popped into the result register once
// that register is free or being emptied; the back end computes its state update
// combinationally from the popped command.
// Reset is synchronous and active low; all sequencer state but the queue entries clears to zero.
// A stalled result holds; the queue absorbs up to FIFO_DEPTH further requests.
`timescale 1ns / 1ps
`include "sprite_command_list_sequencer_core_assert.svh"
module sprite_command_list_sequencer_core
    import scls_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic [15:0]          i_control_word,
    input  logic [15:0]          i_link_word,
    input  logic [15:0]          i_coord_word_a,
    input  logic [15:0]          i_coord_word_b,
    input  logic [15:0]          i_coord_word_c,
    input  logic [15:0]          i_coord_word_d,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_BITS-1:0] o_next_address,
    output logic                 o_drawing_active,
    output logic                 o_end_flag,
    output logic [2:0]           o_draw_kind,
    output logic signed [10:0]   o_origin_x,
    output logic signed [10:0]   o_origin_y,
    output logic [9:0]           o_user_clip_left,
    output logic [8:0]           o_user_clip_top,
    output logic [9:0]           o_user_clip_right,
    output logic [8:0]           o_user_clip_bottom,
    output logic [9:0]           o_system_clip_right,
    output logic [8:0]           o_system_clip_bottom
);

    t_fifo_stat w_stat;
    t_cmd       w_push_cmd;
    t_cmd       w_pop_cmd;
    logic       w_push;
    logic       w_pop;

    // Request intake and classification.
    scls_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_control_word (i_control_word),
        .i_link_word    (i_link_word),
        .i_coord_word_a (i_coord_word_a),
        .i_coord_word_b (i_coord_word_b),
        .i_coord_word_c (i_coord_word_c),
        .i_coord_word_d (i_coord_word_d),
        .i_stat         (w_stat),
        .o_push         (w_push),
        .o_cmd          (w_push_cmd)
    );

    // Queue between the two halves.
    scls_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_stat  (w_stat)
    );

    // Command execution and result register.
    scls_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_stat               (w_stat),
        .i_cmd                (w_pop_cmd),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_next_address       (o_next_address),
        .o_drawing_active     (o_drawing_active),
        .o_end_flag           (o_end_flag),
        .o_draw_kind          (o_draw_kind),
        .o_origin_x           (o_origin_x),
        .o_origin_y           (o_origin_y),
        .o_user_clip_left     (o_user_clip_left),
        .o_user_clip_top      (o_user_clip_top),
        .o_user_clip_right    (o_user_clip_right),
        .o_user_clip_bottom   (o_user_clip_bottom),
        .o_system_clip_right  (o_system_clip_right),
        .o_system_clip_bottom (o_system_clip_bottom)
    );

    // An ended list is never still being walked.
    `SCLS_ASSERT_IMP(a_end_stops, i_clk, i_rst_n, o_end_flag, !o_drawing_active)
    // A drawing kind is only reported by a list that is still running.
    `SCLS_ASSERT_IMP(a_kind_active, i_clk, i_rst_n, o_draw_kind != KIND_NONE, o_drawing_active)
    // Every command address sits on a sixteen-word boundary once out of reset.
    `SCLS_ASSERT_ALW(a_addr_align, i_clk, !i_rst_n || (o_next_address[3:0] == 4'b0000))
    // A taken request is held either in the queue or in the result register.
    `SCLS_ASSERT_NXT(a_req_kept, i_clk, i_rst_n, i_valid && !o_stall, !w_stat.empty || o_valid)

endmodule

// File: test/sprite_command_list_sequencer_core_tb.sv
// Self-checking testbench for the sprite command list sequencer core.
`timescale 1ns / 1ps
module sprite_command_list_sequencer_core_tb;
    import scls_pkg::*;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_COMMAND = 1'b1;

    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_REQUESTS = 750;
    localparam int MAX_GAP         = 5;
    localparam int LONG_HOLD       = 60;
    localparam int LONG_HOLD_AT    = 300;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int SETTLE_CYCLES   = 10;
    localparam int REPORT_LIMIT    = 10;

    // Drawing kinds of codes 0 to 7, three bits per code, code 0 lowest.
    localparam logic [23:0] KIND_BY_CODE = {KIND_POLYLINE, KIND_LINE, KIND_POLYLINE,
        KIND_POLYGON, KIND_DISTORTED, KIND_DISTORTED, KIND_SCALED, KIND_NORMAL};

    // One request on the input channel, plus a flag that makes the sender wait for a drain.
    typedef struct {
        logic        mode;
        logic [15:0] ctl;
        logic [15:0] link;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        bit          drain_first;
    } t_request;

    // One result on the output channel.
    typedef struct packed {
        logic [ADDR_BITS-1:0] next_address;
        logic                 drawing_active;
        logic                 end_flag;
        logic [2:0]           draw_kind;
        logic [10:0]          origin_x;
        logic [10:0]          origin_y;
        logic [9:0]           uclip_left;
        logic [8:0]           uclip_top;
        logic [9:0]           uclip_right;
        logic [8:0]           uclip_bottom;
        logic [9:0]           sclip_right;
        logic [8:0]           sclip_bottom;
    } t_frame;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_mode = 1'b0;
    logic [15:0]          i_control_word = '0;
    logic [15:0]          i_link_word = '0;
    logic [15:0]          i_coord_word_a = '0;
    logic [15:0]          i_coord_word_b = '0;
    logic [15:0]          i_coord_word_c = '0;
    logic [15:0]          i_coord_word_d = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [ADDR_BITS-1:0] o_next_address;
    logic                 o_drawing_active;
    logic                 o_end_flag;
    logic [2:0]           o_draw_kind;
    logic signed [10:0]   o_origin_x;
    logic signed [10:0]   o_origin_y;
    logic [9:0]           o_user_clip_left;
    logic [8:0]           o_user_clip_top;
    logic [9:0]           o_user_clip_right;
    logic [8:0]           o_user_clip_bottom;
    logic [9:0]           o_system_clip_right;
    logic [8:0]           o_system_clip_bottom;

    // Predicted sequencer state.
    logic [ADDR_BITS-1:0] walk_addr = '0;
    logic [ADDR_BITS-1:0] ret_addr = '0;
    logic                 ret_full = 1'b0;
    logic                 walking = 1'b0;
    logic                 end_hit = 1'b0;
    logic [10:0]          org_x = '0;
    logic [10:0]          org_y = '0;
    logic [9:0]           uc_left = '0;
    logic [8:0]           uc_top = '0;
    logic [9:0]           uc_right = '0;
    logic [8:0]           uc_bottom = '0;
    logic [9:0]           sc_right = '0;
    logic [8:0]           sc_bottom = '0;

    t_request pending_requests[$];
    t_frame   expected_frames[$];
    t_request offered;
    int       total_requests;
    int       requests_taken = 0;
    int       send_gap = 0;
    int       results_seen = 0;
    int       fault_count = 0;
    int       hold_left = 0;
    int       results_released = 0;
    bit       long_hold_done = 1'b0;
    int       idle_cycles = 0;

    sprite_command_list_sequencer_core DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_mode               (i_mode),
        .i_control_word       (i_control_word),
        .i_link_word          (i_link_word),
        .i_coord_word_a       (i_coord_word_a),
        .i_coord_word_b       (i_coord_word_b),
        .i_coord_word_c       (i_coord_word_c),
        .i_coord_word_d       (i_coord_word_d),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_next_address       (o_next_address),
        .o_drawing_active     (o_drawing_active),
        .o_end_flag           (o_end_flag),
        .o_draw_kind          (o_draw_kind),
        .o_origin_x           (o_origin_x),
        .o_origin_y           (o_origin_y),
        .o_user_clip_left     (o_user_clip_left),
        .o_user_clip_top      (o_user_clip_top),
        .o_user_clip_right    (o_user_clip_right),
        .o_user_clip_bottom   (o_user_clip_bottom),
        .o_system_clip_right  (o_system_clip_right),
        .o_system_clip_bottom (o_system_clip_bottom)
    );

    // Free-running clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Assembles a control word from its fields.
    function automatic logic [15:0] control(input bit end_bit, input bit skip, input t_link lnk,
                                            input logic [7:0] spare, input logic [3:0] code);
        return {end_bit, skip, lnk, spare, code};
    endfunction

    task automatic add_request(input logic mode, input logic [15:0] ctl, input logic [15:0] link,
                               input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d,
                               input bit drain_first);
        t_request rq;
        rq.mode        = mode;
        rq.ctl         = ctl;
        rq.link        = link;
        rq.word_a      = a;
        rq.word_b      = b;
        rq.word_c      = c;
        rq.word_d      = d;
        rq.drain_first = drain_first;
        pending_requests.push_back(rq);
    endtask

    // Advances the predicted sequencer by one request and returns the result it gives.
    function automatic t_frame step_sequencer(input t_request rq);
        logic [2:0]           kind;
        logic [3:0]           code;
        logic                 halted;
        logic [ADDR_BITS-1:0] target;
        t_frame               f;
        kind   = KIND_NONE;
        code   = rq.ctl[3:0];
        halted = 1'b0;
        target = {rq.link[15:2], 4'b0000};
        if (rq.mode == MODE_START) begin
            end_hit   = 1'b0;
            walk_addr = '0;
            ret_addr  = '0;
            ret_full  = 1'b0;
            walking   = 1'b1;
        end else if (walking) begin
            if (rq.ctl[CTL_END_BIT]) begin
                walking = 1'b0;
                end_hit = 1'b1;
                halted  = 1'b1;
            end else if (!rq.ctl[CTL_SKIP_BIT]) begin
                // Execute the command body.
                if (code >= CODE_STOP_MIN) begin
                    walking = 1'b0;
                    halted  = 1'b1;
                end else if (code < CODE_USER_CLIP) begin
                    kind = KIND_BY_CODE[code*3 +: 3];
                end else if (code == CODE_USER_CLIP || code == CODE_USER_CLIP2) begin
                    uc_left   = rq.word_a[9:0];
                    uc_top    = rq.word_b[8:0];
                    uc_right  = rq.word_c[9:0];
                    uc_bottom = rq.word_d[8:0];
                end else if (code == CODE_SYSTEM_CLIP) begin
                    sc_right  = rq.word_c[9:0];
                    sc_bottom = rq.word_d[8:0];
                end else begin
                    org_x = rq.word_a[10:0];
                    org_y = rq.word_b[10:0];
                end
            end
            // Step to the next command, then apply the link mode.
            if (!halted) begin
                walk_addr = walk_addr + CMD_STRIDE;
                case (t_link'(rq.ctl[13:12]))
                    LINK_JUMP: begin
                        walk_addr = target;
                    end
                    LINK_CALL: begin
                        if (!ret_full) begin
                            ret_addr = walk_addr;
                            ret_full = 1'b1;
                        end
                        walk_addr = target;
                    end
                    LINK_RETURN: begin
                        if (ret_full) begin
                            walk_addr = ret_addr;
                            ret_full  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        f = {walk_addr, walking, end_hit, kind, org_x, org_y,
             uc_left, uc_top, uc_right, uc_bottom, sc_right, sc_bottom};
        return f;
    endfunction

    function automatic string frame_text(input t_frame f);
        return $sformatf("addr=%h act=%b end=%b kind=%0d org=%h,%h uclip=%h,%h,%h,%h sclip=%h,%h",
                         f.next_address, f.drawing_active, f.end_flag, f.draw_kind,
                         f.origin_x, f.origin_y, f.uclip_left, f.uclip_top,
                         f.uclip_right, f.uclip_bottom, f.sclip_right, f.sclip_bottom);
    endfunction

    // Request driver: offers the queued requests with random gaps and predicts each taken one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_frames.push_back(step_sequencer(offered));
                requests_taken++;
                send_gap = (requests_taken % 100 < 20) ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() == 0 ||
                             (pending_requests[0].drain_first && expected_frames.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    offered = pending_requests.pop_front();
                    i_valid        <= 1'b1;
                    i_mode         <= offered.mode;
                    i_control_word <= offered.ctl;
                    i_link_word    <= offered.link;
                    i_coord_word_a <= offered.word_a;
                    i_coord_word_b <= offered.word_b;
                    i_coord_word_c <= offered.word_c;
                    i_coord_word_d <= offered.word_d;
                end
            end
        end
    end

    // Result stall: a random wait after each result, and one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_released++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!long_hold_done && results_released >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall) begin
                hold_left = (results_released % 100 < 20) ? 0 : $urandom_range(0, MAX_GAP);
                if (hold_left > 0) begin
                    hold_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            got = {o_next_address, o_drawing_active, o_end_flag, o_draw_kind,
                   o_origin_x, o_origin_y, o_user_clip_left, o_user_clip_top,
                   o_user_clip_right, o_user_clip_bottom, o_system_clip_right,
                   o_system_clip_bottom};
            results_seen++;
            if (expected_frames.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("result %0d unexpected: %s", results_seen, frame_text(got));
            end else begin
                want = expected_frames.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("result %0d expected %s", results_seen, frame_text(want));
                        $display("result %0d actual   %s", results_seen, frame_text(got));
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or a result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int   random_added;
        int   run_length;
        bit   drain_mid;
        logic [3:0] code;
        i_rst_n = 1'b0;

        // Directed requests: a command before any start is ignored.
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, CODE_USER_CLIP), 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        add_request(MODE_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        // Clip and origin loads at their extremes.
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'hFF, CODE_USER_CLIP), 16'h0000,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, CODE_SYSTEM_CLIP), 16'h0000,
                    16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, CODE_LOCAL_ORG), 16'h0000,
                    16'hFC00, 16'h03FF, 16'hFFFF, 16'hFFFF, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, CODE_USER_CLIP2), 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        // Every drawing code.
        for (int k = 0; k < 8; k++) begin
            code = 4'(k);
            add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, code), 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        end
        // Jump to the last command of the table, then wrap past it.
        add_request(MODE_COMMAND, control(0, 0, LINK_JUMP, 8'h00, 4'h0), 16'hFFFF,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        // Call into an empty slot, call with the slot full, return, return with it empty.
        add_request(MODE_COMMAND, control(0, 0, LINK_CALL, 8'h00, 4'h1), 16'h0043,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_CALL, 8'h00, 4'h2), 16'h0100,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_RETURN, 8'h00, 4'h3), 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_RETURN, 8'h00, 4'h4), 16'h0000,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        // A skipped stop code still advances and jumps.
        add_request(MODE_COMMAND, control(0, 1, LINK_JUMP, 8'h00, 4'hF), 16'h1234,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        // End bit wins over skip; a command after it is ignored.
        add_request(MODE_COMMAND, control(1, 1, LINK_JUMP, 8'h00, 4'h0), 16'h5555,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_NEXT, 8'h00, CODE_LOCAL_ORG), 16'h0000,
                    16'h0123, 16'h0456, 16'h0000, 16'h0000, 0);
        // Restart, restart while walking, then a stop code.
        add_request(MODE_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_CALL, 8'h00, 4'h5), 16'h0800,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
        add_request(MODE_COMMAND, control(0, 0, LINK_JUMP, 8'h00, CODE_STOP_MIN), 16'h0100,
                    16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);

        // Random part: mostly command lists opened by a start, some noise.
        random_added = 0;
        drain_mid    = 1'b0;
        while (random_added < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 9) == 0) begin
                run_length = $urandom_range(1, 8);
                for (int k = 0; k < run_length; k++) begin
                    add_request(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 16'($urandom), 0);
                end
            end else begin
                // Lists opening the random part and its middle wait for a full drain.
                add_request(MODE_START, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom),
                            random_added == 0 ||
                            (!drain_mid && random_added >= RANDOM_REQUESTS / 2));
                if (random_added >= RANDOM_REQUESTS / 2)
                    drain_mid = 1'b1;
                run_length = $urandom_range(2, 30);
                for (int k = 0; k < run_length; k++) begin
                    code = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                        : 4'($urandom_range(0, 11));
                    add_request(MODE_COMMAND,
                                control($urandom_range(0, 24) == 0, $urandom_range(0, 7) == 0,
                                        t_link'($urandom_range(0, 3)), 8'($urandom), code),
                                16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 0);
                end
                run_length++;
            end
            random_added += run_length;
        end
        total_requests = pending_requests.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < total_requests || expected_frames.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && expected_frames.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
